// ===== sv/mel_pkg.sv =====
// ----------------------------------------------------------------------------
// mel_pkg
// Shared types and constants for the motion event logger.
// ----------------------------------------------------------------------------
package mel_pkg;

    // Field widths
    localparam int AXIS_W   = 16;
    localparam int THRESH_W = 18;
    localparam int LIMIT_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int INDEX_W  = 10;
    localparam int KIND_W   = 2;
    localparam int FUNC_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    // Reset values
    localparam logic [THRESH_W-1:0]        THRESH_RESET = 18'd1500;
    localparam logic [LIMIT_W-1:0]         LIMIT_RESET  = 16'd60;
    localparam logic signed [AXIS_W-1:0]   CAL_Z_RESET  = 16'sd1000;
    localparam logic [COUNT_W-1:0]         CNT_MAX      = 16'hFFFF;

    // Output queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE    = 2'd0,
        FUNC_TICK      = 2'd1,
        FUNC_CALIBRATE = 2'd2,
        FUNC_CLEAR     = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_EMPTY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECAL      = 2'd2;

    // Record kinds
    localparam logic [KIND_W-1:0] KIND_COUNT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECAL_IDLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECAL_BUSY = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] index;
        logic               last;
    } record_t;

endpackage

// ===== sv/motion_event_logger_core.sv =====
// ----------------------------------------------------------------------------
// motion_event_logger_core
// Counts movement events from accelerometer samples and logs per-tick records.
// ----------------------------------------------------------------------------
// A record is written to the record queue when its tick is accepted, and the
// master side presents it from there. Throughput: one item per cycle; a tick
// that logs two records pushes both at once into a 4-entry record queue, which
// absorbs them (input stalls when it has fewer than two free slots).
// Reset: asynchronous, active low; registers, calibration (0, 0, 1000), count,
// runs and log position return to their initial values, the queue is emptied.
module motion_event_logger_core #(
    parameter int MAX_RECORDS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mel_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // accel_x, accel_y, accel_z
    input  logic [mel_pkg::FUNC_W-1:0]       s_axis_tuser,  // func
    // master side
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mel_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // record_kind, record_count,
                                                            // record_index, zero pad
    output logic                             m_axis_tlast,
    // configuration
    input  logic                             cfg_we,
    input  logic [mel_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mel_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mel_pkg::*;

    localparam int STORE_W = $clog2(MAX_RECORDS + 1);
    localparam logic [STORE_W-1:0] STORE_LIMIT = STORE_W'(MAX_RECORDS - 1);

    // Configuration registers
    logic [THRESH_W-1:0] thresh_reg;
    logic                skip_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // Input register
    logic                     in_valid_reg;
    logic [FUNC_W-1:0]        in_func_reg;
    logic signed [AXIS_W-1:0] in_x_reg, in_y_reg, in_z_reg;

    // Block state
    logic signed [AXIS_W-1:0] cal_x_reg, cal_y_reg, cal_z_reg;
    logic signed [AXIS_W-1:0] cal_x_next, cal_y_next, cal_z_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic [COUNT_W-1:0]       zrun_reg, zrun_next;
    logic [COUNT_W-1:0]       brun_reg, brun_next;
    logic [STORE_W-1:0]       stored_reg, stored_next;

    // Record queue
    record_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   qcnt_reg, qcnt_next;

    logic                take_item;
    logic                pop;
    logic [1:0]          n_push;
    record_t             rec_first, rec_second;
    record_t             head;

    // Per-item datapath signals
    logic signed [AXIS_W:0] dx, dy, dz;
    logic [AXIS_W:0]        ax_abs, ay_abs, az_abs;
    logic [AXIS_W+2:0]      l1_dist;
    logic                   emit_count, recal;
    logic [COUNT_W-1:0]     zrun_tick, brun_tick;
    logic [STORE_W-1:0]     stored_mid;
    logic [31:0]            idx_wide0, idx_wide1;

    // Handshake
    assign take_item     = in_valid_reg && (qcnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || take_item;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // L1 distance to calibration
    always_comb
    begin
        dx      = {in_x_reg[AXIS_W-1], in_x_reg} - {cal_x_reg[AXIS_W-1], cal_x_reg};
        dy      = {in_y_reg[AXIS_W-1], in_y_reg} - {cal_y_reg[AXIS_W-1], cal_y_reg};
        dz      = {in_z_reg[AXIS_W-1], in_z_reg} - {cal_z_reg[AXIS_W-1], cal_z_reg};
        ax_abs  = dx[AXIS_W] ? (AXIS_W+1)'(-dx) : (AXIS_W+1)'(dx);
        ay_abs  = dy[AXIS_W] ? (AXIS_W+1)'(-dy) : (AXIS_W+1)'(dy);
        az_abs  = dz[AXIS_W] ? (AXIS_W+1)'(-dz) : (AXIS_W+1)'(dz);
        l1_dist = (AXIS_W+3)'(ax_abs) + (AXIS_W+3)'(ay_abs) + (AXIS_W+3)'(az_abs);
    end

    // Item processing: state update and records for one item
    always_comb
    begin
        cal_x_next  = cal_x_reg;
        cal_y_next  = cal_y_reg;
        cal_z_next  = cal_z_reg;
        count_next  = count_reg;
        zrun_next   = zrun_reg;
        brun_next   = brun_reg;
        stored_next = stored_reg;
        emit_count  = 1'b0;
        recal       = 1'b0;
        zrun_tick   = zrun_reg;
        brun_tick   = brun_reg;
        stored_mid  = stored_reg;
        n_push      = 2'd0;
        idx_wide0   = 32'(stored_reg);
        idx_wide1   = 32'(stored_reg);
        rec_first   = '0;
        rec_second  = '0;

        if (take_item)
        begin
            case (func_t'(in_func_reg))
                FUNC_SAMPLE:
                begin
                    if ((l1_dist > (AXIS_W+3)'(thresh_reg)) && (count_reg != CNT_MAX))
                        count_next = count_reg + 1'b1;
                end
                FUNC_TICK:
                begin
                    if (stored_reg < STORE_LIMIT)
                    begin
                        // run tracking
                        if (count_reg == '0)
                        begin
                            zrun_tick = (zrun_reg != CNT_MAX) ? zrun_reg + 1'b1 : zrun_reg;
                            brun_tick = '0;
                        end
                        else
                        begin
                            zrun_tick = '0;
                            brun_tick = (brun_reg != CNT_MAX) ? brun_reg + 1'b1 : brun_reg;
                        end
                        zrun_next = zrun_tick;
                        brun_next = brun_tick;

                        // count record
                        emit_count = !skip_reg || (count_reg != '0);
                        if (emit_count)
                        begin
                            count_next = '0;
                            stored_mid = stored_reg + 1'b1;
                        end
                        idx_wide1 = 32'(stored_mid);

                        // recalibration marker
                        recal = (zrun_tick > limit_reg) || (brun_tick > limit_reg);
                        stored_next = recal ? stored_mid + 1'b1 : stored_mid;
                        if (recal)
                        begin
                            cal_x_next = in_x_reg;
                            cal_y_next = in_y_reg;
                            cal_z_next = in_z_reg;
                            zrun_next  = '0;
                            brun_next  = '0;
                        end

                        rec_second.kind  = (zrun_tick != '0) ? KIND_RECAL_IDLE
                                                             : KIND_RECAL_BUSY;
                        rec_second.count = '0;
                        rec_second.index = idx_wide1[INDEX_W-1:0];
                        rec_second.last  = 1'b1;

                        if (emit_count)
                        begin
                            rec_first.kind  = KIND_COUNT;
                            rec_first.count = count_reg;
                            rec_first.index = idx_wide0[INDEX_W-1:0];
                            rec_first.last  = !recal;
                            n_push = recal ? 2'd2 : 2'd1;
                        end
                        else if (recal)
                        begin
                            rec_first = rec_second;
                            n_push    = 2'd1;
                        end
                    end
                end
                FUNC_CALIBRATE:
                begin
                    cal_x_next = in_x_reg;
                    cal_y_next = in_y_reg;
                    cal_z_next = in_z_reg;
                end
                default:
                begin
                    count_next  = '0;
                    stored_next = '0;
                end
            endcase
        end
    end

    // Queue occupancy
    assign qcnt_next = qcnt_reg + QCNT_W'(n_push) - QCNT_W'(pop);

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg   <= THRESH_RESET;
            skip_reg     <= 1'b0;
            limit_reg    <= LIMIT_RESET;
            in_valid_reg <= 1'b0;
            cal_x_reg    <= '0;
            cal_y_reg    <= '0;
            cal_z_reg    <= CAL_Z_RESET;
            count_reg    <= '0;
            zrun_reg     <= '0;
            brun_reg     <= '0;
            stored_reg   <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            qcnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESHOLD:  thresh_reg <= cfg_data[THRESH_W-1:0];
                    REG_SKIP_EMPTY: skip_reg   <= cfg_data[0];
                    REG_RECAL:      limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default:        ;
                endcase
            end
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            cal_x_reg  <= cal_x_next;
            cal_y_reg  <= cal_y_next;
            cal_z_reg  <= cal_z_next;
            count_reg  <= count_next;
            zrun_reg   <= zrun_next;
            brun_reg   <= brun_next;
            stored_reg <= stored_next;
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_push);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            qcnt_reg   <= qcnt_next;
        end
    end

    // Input payload and queue entries
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_func_reg <= s_axis_tuser;
            in_x_reg    <= s_axis_tdata[AXIS_W-1:0];
            in_y_reg    <= s_axis_tdata[2*AXIS_W-1:AXIS_W];
            in_z_reg    <= s_axis_tdata[3*AXIS_W-1:2*AXIS_W];
        end
        if (n_push != 2'd0)
            queue_reg[wr_ptr_reg] <= rec_first;
        if (n_push == 2'd2)
            queue_reg[wr_ptr_reg + 1'b1] <= rec_second;
    end

    // Master side
    assign head          = queue_reg[rd_ptr_reg];
    assign m_axis_tvalid = (qcnt_reg != '0);
    assign m_axis_tdata  = {4'b0, head.index, head.count, head.kind};
    assign m_axis_tlast  = head.last;

    // Checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("record queue overflow");

    a_log_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= STORE_W'(MAX_RECORDS))
        else $error("log position beyond capacity");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && n_push == 2'd0) |=> (qcnt_reg == $past(qcnt_reg) - 1'b1))
        else $error("queue count did not drop on pop");

    a_full_log_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (stored_reg >= STORE_LIMIT) |-> (n_push == 2'd0))
        else $error("record emitted with full log");

endmodule
